// ===== rtl/core/sle_pkg.sv =====
// Shared types, character constants and helper functions for the string
// literal escaper. No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int unsigned CpW              = 21;
  localparam int unsigned FuncW            = 2;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned LenW             = 4;
  localparam int unsigned FifoDepthDefault = 4;

  // Request kinds on the input channel.
  localparam logic [FuncW-1:0] FuncBegin     = 2'd0;
  localparam logic [FuncW-1:0] FuncCodePoint = 2'd1;
  localparam logic [FuncW-1:0] FuncEnd       = 2'd2;

  localparam logic [ByteW-1:0] ChrQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChrBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChrLowerU    = 8'h75;
  localparam logic [ByteW-1:0] ChrUpperU    = 8'h55;

  localparam logic [CpW-1:0] PrintLow = 21'h00020;
  localparam logic [CpW-1:0] PrintEnd = 21'h0007F;
  localparam logic [CpW-1:0] BmpEnd   = 21'h10000;

  typedef enum logic [1:0] {
    KIND_LIT,   // one byte, taken from the value
    KIND_PAIR,  // backslash, then the byte in the value
    KIND_HEX4,  // backslash, u, four hex digits
    KIND_HEX8   // backslash, U, eight hex digits
  } kind_e;

  typedef struct packed {
    kind_e          kind;
    logic [CpW-1:0] value;
  } desc_t;

  function automatic logic [LenW-1:0] kind_len(input kind_e kind);
    logic [LenW-1:0] len;
    unique case (kind)
      KIND_LIT:  len = 4'd1;
      KIND_PAIR: len = 4'd2;
      KIND_HEX4: len = 4'd6;
      KIND_HEX8: len = 4'd10;
      default:   len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    logic [ByteW-1:0] chr;
    if (nib < 4'd10) begin
      chr = 8'h30 + {4'd0, nib};
    end else begin
      chr = 8'h57 + {4'd0, nib};
    end
    return chr;
  endfunction

endpackage

// ===== rtl/core/string_literal_escaper.sv =====
// Channel | dir | tdata                 | tuser     | tlast
// s_axis  | in  | [20:0] code_point     | [1:0] func| -
// m_axis  | out | [7:0] out_byte        | -         | run_end
//
// A request is taken every cycle while the descriptor queue has room; the
// output side moves one byte per cycle unless the sink stalls; an item is
// 1, 2, 6 or 10 bytes. A byte crosses classifier, queue and output registers.
// Reset clears all valid flags and queue pointers; no clearing pass.
// Either side may stall freely: the queue decouples classifier and emitter.
// Top level of the string literal escaper; depends on sle_pkg, sle_classify,
// sle_fifo and sle_emit.
`timescale 1ns / 1ps

module string_literal_escaper #(
  parameter int unsigned FifoDepth = sle_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [20:0] code_point, [23:21] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o
);
  import sle_pkg::*;

  logic  push_valid, push_ready;
  desc_t push_desc;
  logic  head_valid, head_pop;
  desc_t head_desc;

  sle_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_func_i    (s_axis_tuser_i),
    .in_cp_i      (s_axis_tdata_i[CpW-1:0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  sle_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_pop),
    .pop_desc_o   (head_desc)
  );

  sle_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .head_desc_i  (head_desc),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ===== rtl/core/sle_classify.sv =====
// Front end: accepts requests, sorts each code point into an escape kind and
// holds the resulting descriptor for the queue. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_classify (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_func_i,
  input  logic [20:0]           in_cp_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output sle_pkg::desc_t        push_desc_o
);
  import sle_pkg::*;

  logic  valid_q, valid_d;
  desc_t desc_q, desc_d;
  logic  take;
  logic  keep;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    desc_d.kind  = KIND_LIT;
    desc_d.value = in_cp_i;
    keep         = 1'b1;
    unique case (in_func_i)
      FuncBegin, FuncEnd: begin
        desc_d.kind  = KIND_LIT;
        desc_d.value = {{(CpW-ByteW){1'b0}}, ChrQuote};
      end
      FuncCodePoint: begin
        priority if (in_cp_i == 21'h08) begin
          desc_d.kind  = KIND_PAIR;
          desc_d.value = 21'h62;
        end else if (in_cp_i == 21'h0C) begin
          desc_d.kind  = KIND_PAIR;
          desc_d.value = 21'h66;
        end else if (in_cp_i == 21'h0A) begin
          desc_d.kind  = KIND_PAIR;
          desc_d.value = 21'h6E;
        end else if (in_cp_i == 21'h0D) begin
          desc_d.kind  = KIND_PAIR;
          desc_d.value = 21'h72;
        end else if (in_cp_i == 21'h09) begin
          desc_d.kind  = KIND_PAIR;
          desc_d.value = 21'h74;
        end else if (in_cp_i == {{(CpW-ByteW){1'b0}}, ChrQuote} ||
                     in_cp_i == {{(CpW-ByteW){1'b0}}, ChrBackslash}) begin
          desc_d.kind = KIND_PAIR;
        end else if (in_cp_i >= PrintLow && in_cp_i < PrintEnd) begin
          desc_d.kind = KIND_LIT;
        end else if (in_cp_i < BmpEnd) begin
          desc_d.kind = KIND_HEX4;
        end else begin
          desc_d.kind = KIND_HEX8;
        end
      end
      default: keep = 1'b0;  // unused selector produces nothing
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = keep;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      desc_q <= desc_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_desc_o  = desc_q;

endmodule

// ===== rtl/core/sle_fifo.sv =====
// Short descriptor queue between the classifier and the byte emitter.
// Depends on sle_pkg for the descriptor type.
`timescale 1ns / 1ps

module sle_fifo #(
  parameter int unsigned Depth = sle_pkg::FifoDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sle_pkg::desc_t push_desc_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output sle_pkg::desc_t pop_desc_o
);
  import sle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_desc_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// ===== rtl/core/sle_emit.sv =====
// Back end: walks the descriptor at the head of the queue into a registered
// output stage, one byte per cycle unless stalled. Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  output logic           head_pop_o,
  input  sle_pkg::desc_t head_desc_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import sle_pkg::*;

  logic [LenW-1:0]  idx_q, idx_d;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  pos;
  logic             load;
  logic             last;
  logic [31:0]      val_ext;
  logic [3:0]       nib;
  logic [ByteW-1:0] byte_d;
  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;

  assign len     = kind_len(head_desc_i.kind);
  assign load    = !valid_q || out_ready_i;
  assign last    = idx_q == len - 1'b1;
  assign head_pop_o = load && head_valid_i && last;

  // Hex digits go out most significant first.
  assign pos     = len - 1'b1 - idx_q;
  assign val_ext = {{(32-CpW){1'b0}}, head_desc_i.value};
  assign nib     = 4'(val_ext >> {pos[2:0], 2'b00});

  always_comb begin
    if (idx_q == 4'd0) begin
      byte_d = (head_desc_i.kind == KIND_LIT) ? head_desc_i.value[ByteW-1:0] : ChrBackslash;
    end else if (idx_q == 4'd1) begin
      unique case (head_desc_i.kind)
        KIND_HEX4: byte_d = ChrLowerU;
        KIND_HEX8: byte_d = ChrUpperU;
        default:   byte_d = head_desc_i.value[ByteW-1:0];
      endcase
    end else begin
      byte_d = hex_char(nib);
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        idx_d = last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      byte_q <= byte_d;
      last_q <= last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// ===== rtl/core/sle_checker.sv =====
// Port-level checks for the string literal escaper, bound to the top level.
// Depends on sle_pkg for character constants.
`timescale 1ns / 1ps

module sle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i,
  input logic       m_tlast_i
);
  import sle_pkg::*;

  logic [LenW-1:0] run_cnt_q;
  logic            m_take;

  assign m_take = m_tvalid_i && m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
    end else if (m_take) begin
      run_cnt_q <= m_tlast_i ? '0 : run_cnt_q + 1'b1;
    end
  end

  // The output stage is empty from the first edge after reset is seen.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_tvalid_i)
    else $error("output valid during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i) && $stable(m_tlast_i))
    else $error("output payload changed while stalled");

  // No escape is longer than ten bytes.
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_take && !m_tlast_i |-> run_cnt_q < 4'd9)
    else $error("run longer than ten bytes");

  // A one-byte run is never a bare backslash.
  a_no_lone_bs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_take && m_tlast_i && run_cnt_q == '0 |-> m_tdata_i != ChrBackslash)
    else $error("lone backslash emitted");

endmodule

bind string_literal_escaper sle_checker u_sle_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);
